@@ src/button_encoder_event_queue_top_defines.svh @@
// Assertion macros used by the button and encoder event queue checker.
`ifndef BUTTON_ENCODER_EVENT_QUEUE_TOP_DEFINES_SVH
`define BUTTON_ENCODER_EVENT_QUEUE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("beq check failed");

// Check that cons holds in the cycle after ante.
`define BEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("beq check failed");

`endif

@@ src/beq_pkg.sv @@
// Shared constants, event types and slot types of the button and encoder event queue.
package beq_pkg;

	localparam int Buttons    = 4;
	localparam int QueueDepth = 8;
	localparam int LevelW     = 4;
	localparam int NSlots     = Buttons + 1;
	localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW       = $clog2(QueueDepth + NSlots + 1);
	localparam int PaddrW     = 3;
	localparam int PosW       = 30;

	localparam logic [15:0] RstLongPress = 16'd500;
	localparam logic [7:0]  RstSettle    = 8'd10;

	typedef enum logic [1:0] {
		KIND_TURN  = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_LONG  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  button;
		logic [7:0]  delta;
	} event_t;

	// One candidate event produced by a lane for the current poll.
	typedef struct packed {
		logic   hit;
		event_t ev;
	} slot_t;

	typedef logic [PtrW-1:0] ptr_t;
	typedef logic [CntW-1:0] cnt_t;

endpackage

@@ src/beq_if.sv @@
// Poll and event channel interfaces with valid/ready handshake.
interface beq_poll_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic [3:0]         button_levels;
	logic signed [31:0] encoder_count;

	modport source (output valid, output now_ms, output button_levels,
		output encoder_count, input ready);
	modport sink (input valid, input now_ms, input button_levels,
		input encoder_count, output ready);
endinterface

interface beq_event_if;
	logic              valid;
	logic              ready;
	logic              event_valid;
	logic [1:0]        event_kind;
	logic [1:0]        button_index;
	logic signed [7:0] turn_delta;

	modport source (output valid, output event_valid, output event_kind,
		output button_index, output turn_delta, input ready);
	modport sink (input valid, input event_valid, input event_kind,
		input button_index, input turn_delta, output ready);
endinterface

@@ src/button_encoder_event_queue_top.sv @@
// Top level of the button debounce and encoder event queue.
//
//   channel  dir  handshake            payload
//   poll     in   valid/ready          now_ms, button_levels, encoder_count
//   evt      out  valid/ready          event_valid, event_kind, button_index, turn_delta
//   apb      in   psel/penable/pready  hold time @ 0x0, settle time @ 0x4
//
// One poll per cycle sustained while evt is not stalled; each result passes through the
// lane register, then the output register, before it is offered on evt.
// The button and encoder lanes update in the accept cycle; the merge stage
// writes up to one event per lane into the queue and pops at most one in the same cycle.
// The output register stalls the merge stage, which in turn stalls the poll side.
// Reset clears all lane state, queue pointers and valids; no clearing pass.
module button_encoder_event_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	beq_poll_if.sink                    poll,
	beq_event_if.source                 evt,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [beq_pkg::PaddrW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import beq_pkg::*;

	localparam logic REG_LONG_PRESS = 1'b0;
	localparam logic REG_SETTLE     = 1'b1;

	logic [15:0] long_press_q;
	logic [7:0]  settle_q;
	logic        cfg_wr;
	logic        reg_sel;

	logic        accept;
	logic        s1_valid_q;
	logic        s1_take;
	slot_t       slots [NSlots];

	// Decode configuration writes and reads
	assign pready  = 1'b1;
	assign reg_sel = paddr[PaddrW-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= RstLongPress;
			settle_q     <= RstSettle;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_LONG_PRESS: long_press_q <= pwdata[15:0];
				REG_SETTLE:     settle_q     <= pwdata[7:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_LONG_PRESS: prdata = {16'd0, long_press_q};
			REG_SETTLE:     prdata = {24'd0, settle_q};
			default:        prdata = '0;
		endcase
	end

	// Accept a poll when the lane outputs are free or moving on
	assign poll.ready = !s1_valid_q || s1_take;
	assign accept     = poll.valid && poll.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Encoder lane takes the first slot so turns queue ahead of presses
	beq_encoder_lane u_enc (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.encoder_count (poll.encoder_count),
		.slot_s1       (slots[0])
	);

	// One lane per button, buttons beyond the level field read as released
	for (genvar i = 0; i < Buttons; i++) begin : g_btn
		logic raw;
		if (i < LevelW) begin : g_lvl
			assign raw = poll.button_levels[i];
		end else begin : g_zero
			assign raw = 1'b0;
		end

		beq_button_lane u_btn (
			.clk           (clk),
			.arst_n        (arst_n),
			.load          (accept),
			.raw           (raw),
			.now_ms        (poll.now_ms),
			.settle_ms     (settle_q),
			.hold_ms       (long_press_q),
			.button_id     (2'(i)),
			.slot_s1       (slots[i+1])
		);
	end

	beq_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid_q),
		.slots    (slots),
		.s1_take  (s1_take),
		.evt      (evt)
	);

endmodule

@@ src/beq_encoder_lane.sv @@
// Encoder lane: detent position tracking and turn event detection.
module beq_encoder_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic signed [31:0] encoder_count,
	output beq_pkg::slot_t     slot_s1
);
	import beq_pkg::*;

	logic [31:0]     biased;
	logic [PosW-1:0] pos;
	logic [PosW-1:0] diff;
	logic [PosW-1:0] base_q;
	logic            turn;

	// Divide by four, truncating toward zero: bias negatives by three first
	always_comb begin
		biased = encoder_count + {30'd0, {2{encoder_count[31]}}};
		pos    = biased[31:2];
		diff   = pos - base_q;
		turn   = (pos != base_q);
	end

	// Track the baseline detent, moved only when a turn is reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (load && turn) begin
			base_q <= pos;
		end
	end

	// Capture the turn candidate for the merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
		end else if (load) begin
			slot_s1.hit       <= turn;
			slot_s1.ev.kind   <= KIND_TURN;
			slot_s1.ev.button <= 2'd0;
			slot_s1.ev.delta  <= diff[7:0];
		end
	end

endmodule

@@ src/beq_button_lane.sv @@
// Button lane: settle-time debounce, short press on release, long press on hold.
module beq_button_lane (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           raw,
	input  logic [31:0]    now_ms,
	input  logic [7:0]     settle_ms,
	input  logic [15:0]    hold_ms,
	input  logic [1:0]     button_id,
	output beq_pkg::slot_t slot_s1
);
	import beq_pkg::*;

	logic        level_last_q;
	logic [31:0] change_time_q;
	logic        debounced_q;
	logic [31:0] press_time_q;
	logic        long_done_q;

	logic        changed;
	logic        settled;
	logic        press;
	logic        release_ev;
	logic        deb_n;
	logic        long_done_n;
	logic [31:0] hold_el;
	logic        long_ev;
	logic        short_ev;

	// Evaluate the debounce window and the hold time for this poll
	always_comb begin
		changed     = (raw != level_last_q);
		settled     = changed ? (settle_ms == 8'd0)
			: ((now_ms - change_time_q) >= {24'd0, settle_ms});
		press       = settled && raw && !debounced_q;
		release_ev  = settled && !raw && debounced_q;
		deb_n       = press ? 1'b1 : (release_ev ? 1'b0 : debounced_q);
		long_done_n = press ? 1'b0 : long_done_q;
		hold_el     = press ? 32'd0 : (now_ms - press_time_q);
		long_ev     = deb_n && !long_done_n && (hold_el >= {16'd0, hold_ms});
		short_ev    = release_ev && !long_done_q;
	end

	// Advance the lane state on each accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_last_q  <= 1'b0;
			change_time_q <= '0;
			debounced_q   <= 1'b0;
			press_time_q  <= '0;
			long_done_q   <= 1'b0;
		end else if (load) begin
			level_last_q <= raw;
			if (changed) begin
				change_time_q <= now_ms;
			end
			debounced_q <= deb_n;
			if (press) begin
				press_time_q <= now_ms;
			end
			long_done_q <= long_ev ? 1'b1 : long_done_n;
		end
	end

	// Capture the press candidate for the merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
		end else if (load) begin
			slot_s1.hit       <= long_ev || short_ev;
			slot_s1.ev.kind   <= long_ev ? KIND_LONG : KIND_SHORT;
			slot_s1.ev.button <= button_id;
			slot_s1.ev.delta  <= 8'd0;
		end
	end

endmodule

@@ src/beq_merge.sv @@
// Merge stage: packs lane events into the event queue in order, pops at most one per poll.
module beq_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s1_valid,
	input  beq_pkg::slot_t      slots [beq_pkg::NSlots],
	output logic                s1_take,
	beq_event_if.source         evt
);
	import beq_pkg::*;

	localparam cnt_t Depth   = cnt_t'(QueueDepth);
	localparam cnt_t DepthM1 = cnt_t'(QueueDepth - 1);
	localparam ptr_t LastPtr = ptr_t'(QueueDepth - 1);

	event_t store_q [QueueDepth];
	ptr_t   rp_q;
	ptr_t   wp_q;

	logic   out_valid_q;
	logic   out_hit_q;
	event_t out_ev_q;

	cnt_t   occ;
	cnt_t   free_slots;
	cnt_t   rank;
	cnt_t   addr_sum;
	logic   acc   [NSlots];
	ptr_t   addr  [NSlots];
	cnt_t   n_acc;
	cnt_t   wp_sum;
	ptr_t   wp_n;
	ptr_t   rp_n;
	event_t first_ev;
	logic   pop_some;
	event_t pop_ev;

	assign s1_take = s1_valid && (!out_valid_q || evt.ready);

	// Rank the candidates, keep those that fit, find the pop entry
	always_comb begin
		occ        = (wp_q >= rp_q) ? (cnt_t'(wp_q) - cnt_t'(rp_q))
			: (cnt_t'(wp_q) + Depth - cnt_t'(rp_q));
		free_slots = DepthM1 - occ;
		rank       = '0;
		first_ev   = '0;
		for (int j = 0; j < NSlots; j++) begin
			acc[j]   = slots[j].hit && (rank < free_slots);
			addr_sum = cnt_t'(wp_q) + rank;
			addr[j]  = (addr_sum >= Depth) ? ptr_t'(addr_sum - Depth) : ptr_t'(addr_sum);
			rank     = rank + cnt_t'(slots[j].hit);
		end
		for (int j = NSlots - 1; j >= 0; j--) begin
			if (slots[j].hit) begin
				first_ev = slots[j].ev;
			end
		end
		n_acc    = (rank < free_slots) ? rank : free_slots;
		wp_sum   = cnt_t'(wp_q) + n_acc;
		wp_n     = (wp_sum >= Depth) ? ptr_t'(wp_sum - Depth) : ptr_t'(wp_sum);
		pop_some = (rp_q != wp_n);
		// An empty queue pops the first event written in this same poll
		pop_ev   = (occ == '0) ? first_ev : store_q[rp_q];
		rp_n     = pop_some ? ((rp_q == LastPtr) ? '0 : rp_q + ptr_t'(1)) : rp_q;
	end

	// Write accepted events into their queue entries
	always_ff @(posedge clk) begin
		for (int k = 0; k < QueueDepth; k++) begin
			for (int j = 0; j < NSlots; j++) begin
				if (s1_take && acc[j] && (addr[j] == ptr_t'(k))) begin
					store_q[k] <= slots[j].ev;
				end
			end
		end
	end

	// Advance the queue pointers and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			rp_q        <= rp_n;
			wp_q        <= wp_n;
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result item until it is taken
	always_ff @(posedge clk) begin
		if (s1_take) begin
			out_hit_q <= pop_some;
			out_ev_q  <= pop_some ? pop_ev : '0;
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.event_valid  = out_hit_q;
	assign evt.event_kind   = out_ev_q.kind;
	assign evt.button_index = out_ev_q.button;
	assign evt.turn_delta   = $signed(out_ev_q.delta);

endmodule

@@ src/beq_checker.sv @@
// Port-level checks on the event queue top, bound to every instance.
`include "button_encoder_event_queue_top_defines.svh"

module beq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              ev_valid,
	input logic              ev_ready,
	input logic              event_valid,
	input logic [1:0]        event_kind,
	input logic [1:0]        button_index,
	input logic signed [7:0] turn_delta
);
	import beq_pkg::*;

	// A result item holds while stalled
	`BEQ_ASSERT_NEXT(a_evt_hold, clk, arst_n, ev_valid && !ev_ready, ev_valid)

	// An empty pop reports all fields zero
	`BEQ_ASSERT_NOW(a_empty_zero, clk, arst_n, ev_valid && !event_valid, event_kind == KIND_TURN && button_index == 2'd0 && turn_delta == 8'sd0)

	// Turn events carry no button
	`BEQ_ASSERT_NOW(a_turn_button, clk, arst_n, ev_valid && event_valid && event_kind == KIND_TURN, button_index == 2'd0)

	// Press events carry no delta
	`BEQ_ASSERT_NOW(a_press_delta, clk, arst_n, ev_valid && event_valid && event_kind != KIND_TURN, turn_delta == 8'sd0)

endmodule

bind button_encoder_event_queue_top beq_checker u_beq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.ev_valid     (evt.valid),
	.ev_ready     (evt.ready),
	.event_valid  (evt.event_valid),
	.event_kind   (evt.event_kind),
	.button_index (evt.button_index),
	.turn_delta   (evt.turn_delta)
);
